// ===== hdl/pidlp_pkg.sv =====
// ----------------------------------------------------------------------------
// pidlp_pkg
// Shared types, codes and helpers for the filtered-term PID controller.
// ----------------------------------------------------------------------------
package pidlp_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Dividend width of the shared divider (holds every rounded numerator).
  localparam int NUM_W  = 66;
  // Multiplier operand and product widths.
  localparam int MA_W   = 35;
  localparam int MB_W   = 33;
  localparam int PROD_W = MA_W + MB_W;
  // Integral step is clamped to +-2^TERM_SH; anything beyond clamps anyway.
  localparam int TERM_SH = 33;
  localparam int TERM_W  = TERM_SH + 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_P_TC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_I_TC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_D_TC   = 3'd5;

  // Filter slots.
  localparam logic [1:0] FILT_P = 2'd0;
  localparam logic [1:0] FILT_I = 2'd1;
  localparam logic [1:0] FILT_D = 2'd2;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LATCH,
    OP_MUL_TCF,
    OP_MUL_DTE,
    OP_NUM_ADD,
    OP_FDIV_GO,
    OP_WAIT,
    OP_FDIV_END,
    OP_MUL_P,
    OP_P_TAKE,
    OP_MUL_I,
    OP_T_TAKE,
    OP_MUL_TDT,
    OP_I_TAKE,
    OP_MUL_D,
    OP_DDIV_GO,
    OP_DDIV_END,
    OP_SUM
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_MUL_TC,
    ST_F_MUL_DT,
    ST_F_ADD,
    ST_F_DIV,
    ST_F_WAIT,
    ST_P_MUL,
    ST_P_TAKE,
    ST_I_MUL,
    ST_I_TAKE,
    ST_I_MUL_DT,
    ST_I_ADD,
    ST_D_MUL,
    ST_D_DIV,
    ST_D_WAIT,
    ST_SUM
  } ctrl_st_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [31:0] v;
    logic        hit;
  } sat32_t;

  // Clamp to the 32-bit signed range; flag when the value lay outside it.
  function automatic sat32_t sat32(input logic signed [PROD_W-1:0] x);
    sat32_t r;
    logic   fits;
    fits = (x[PROD_W-1:31] == '0) || (x[PROD_W-1:31] == '1);
    r.hit = !fits;
    if (fits) begin
      r.v = x[31:0];
    end else if (x[PROD_W-1]) begin
      r.v = 32'h8000_0000;
    end else begin
      r.v = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== hdl/pidlp_div.sv =====
// ----------------------------------------------------------------------------
// pidlp_div
// Shared restoring divider, one quotient bit per cycle, round half away.
// ----------------------------------------------------------------------------
module pidlp_div #(
  parameter int NUM_W = pidlp_pkg::NUM_W,
  parameter int DEN_W = 40
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    busy,
  output logic                    done,
  output logic signed [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] rq_r, rq_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic signed [NUM_W-1:0] quot_r, quot_nxt;

  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    mag   = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    trial = {rem_r, rq_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rq_nxt   = rq_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    quot_nxt = quot_r;
    if (start) begin
      // Bias by half the divisor so truncation rounds to nearest.
      rq_nxt   = mag + NUM_W'(den >> 1);
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[NUM_W-1];
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        rq_nxt  = {rq_r[NUM_W-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
      end else begin
        quot_nxt = neg_r ? -$signed(rq_r) : $signed(rq_r);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rq_r   <= rq_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r && !done_r)
    else $error("divider started while busy");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r) && $past(cnt_r) == '0)
    else $error("divider done without finishing its steps");

endmodule

// ===== hdl/pidlp_dp.sv =====
// ----------------------------------------------------------------------------
// pidlp_dp
// Datapath: config and filter state, shared multiplier, divider, output reg.
// ----------------------------------------------------------------------------
module pidlp_dp #(
  parameter int FRAC_BITS = pidlp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pidlp_pkg::dp_cmd_t                  cmd,
  output pidlp_pkg::dp_stat_t                 stat,
  input  logic                                cfg_we,
  input  logic [pidlp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic signed [31:0]                  in_error_sample,
  input  logic [15:0]                         in_elapsed_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  out_drive,
  output logic                                out_saturated
);

  localparam int NUM_W  = pidlp_pkg::NUM_W;
  localparam int MA_W   = pidlp_pkg::MA_W;
  localparam int MB_W   = pidlp_pkg::MB_W;
  localparam int PROD_W = pidlp_pkg::PROD_W;
  localparam int TERM_W = pidlp_pkg::TERM_W;
  localparam int DEN_W  = (16 + FRAC_BITS > 25) ? 16 + FRAC_BITS : 25;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] T_MAX = PROD_W'(1) << pidlp_pkg::TERM_SH;
  localparam logic signed [PROD_W-1:0] T_MIN = -T_MAX;

  logic signed [31:0] kp_r, ki_r, kd_r;
  logic [23:0]        tc_r [3];
  logic signed [31:0] filt_r [3];
  logic signed [31:0] prev_r, integ_r;
  logic signed [31:0] e_r;
  logic [15:0]        dt_r;
  logic signed [PROD_W-1:0] prod_r, acc_r, p_r;
  logic signed [TERM_W-1:0] t_r;
  logic signed [NUM_W-1:0]  d_r;
  logic               sat_r;
  logic               out_valid_r;
  logic signed [31:0] drive_r;
  logic               out_sat_r;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [32:0]     ddiff;
  logic                   div_start, div_busy, div_done;
  logic signed [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0]        div_den;
  logic signed [PROD_W-1:0] rnd, tcl, isum, fsum;
  pidlp_pkg::sat32_t      isat, fsat;

  function automatic logic signed [PROD_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] x);
    logic [PROD_W-1:0] mag, r;
    mag = x[PROD_W-1] ? -x : x;
    r   = (mag + HALF) >> FRAC_BITS;
    return x[PROD_W-1] ? -$signed(r) : $signed(r);
  endfunction

  // Operand select for the shared multiplier.
  always_comb begin
    ddiff = 33'(filt_r[pidlp_pkg::FILT_D]) - 33'(prev_r);
    ma = '0;
    mb = '0;
    case (cmd.op)
      pidlp_pkg::OP_MUL_TCF: begin
        ma = MA_W'(filt_r[cmd.idx]);
        mb = $signed({9'b0, tc_r[cmd.idx]});
      end
      pidlp_pkg::OP_MUL_DTE: begin
        ma = MA_W'(e_r);
        mb = $signed({17'b0, dt_r});
      end
      pidlp_pkg::OP_MUL_P: begin
        ma = MA_W'(filt_r[pidlp_pkg::FILT_P]);
        mb = MB_W'(kp_r);
      end
      pidlp_pkg::OP_MUL_I: begin
        ma = MA_W'(filt_r[pidlp_pkg::FILT_I]);
        mb = MB_W'(ki_r);
      end
      pidlp_pkg::OP_MUL_TDT: begin
        ma = t_r;
        mb = $signed({17'b0, dt_r});
      end
      pidlp_pkg::OP_MUL_D: begin
        ma = MA_W'(ddiff);
        mb = MB_W'(kd_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    rnd  = rnd_shift(prod_r);
    tcl  = (rnd > T_MAX) ? T_MAX : ((rnd < T_MIN) ? T_MIN : rnd);
    isum = PROD_W'(integ_r) + prod_r;
    isat = pidlp_pkg::sat32(isum);
    fsum = p_r + PROD_W'(integ_r) + PROD_W'(d_r);
    fsat = pidlp_pkg::sat32(fsum);
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = acc_r[NUM_W-1:0];
    div_den   = DEN_W'(tc_r[cmd.idx]) + DEN_W'(dt_r);
    if (cmd.op == pidlp_pkg::OP_FDIV_GO) begin
      div_start = 1'b1;
    end else if (cmd.op == pidlp_pkg::OP_DDIV_GO) begin
      div_start = 1'b1;
      div_num   = prod_r[NUM_W-1:0];
      div_den   = DEN_W'({dt_r, {FRAC_BITS{1'b0}}});
    end
  end

  pidlp_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  // Config and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      tc_r    <= '{default: '0};
      filt_r  <= '{default: '0};
      prev_r  <= '0;
      integ_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pidlp_pkg::CFG_P_GAIN: kp_r <= cfg_data;
          pidlp_pkg::CFG_I_GAIN: ki_r <= cfg_data;
          pidlp_pkg::CFG_D_GAIN: kd_r <= cfg_data;
          pidlp_pkg::CFG_P_TC:   tc_r[pidlp_pkg::FILT_P] <= cfg_data[23:0];
          pidlp_pkg::CFG_I_TC:   tc_r[pidlp_pkg::FILT_I] <= cfg_data[23:0];
          pidlp_pkg::CFG_D_TC:   tc_r[pidlp_pkg::FILT_D] <= cfg_data[23:0];
          default: ;
        endcase
      end
      case (cmd.op)
        pidlp_pkg::OP_FDIV_END: filt_r[cmd.idx] <= div_quot[31:0];
        pidlp_pkg::OP_I_TAKE:   integ_r <= isat.v;
        pidlp_pkg::OP_DDIV_END: prev_r <= filt_r[pidlp_pkg::FILT_D];
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (cmd.op)
      pidlp_pkg::OP_LATCH: begin
        e_r   <= in_error_sample;
        dt_r  <= (in_elapsed_ticks == '0) ? 16'd1 : in_elapsed_ticks;
        sat_r <= 1'b0;
      end
      pidlp_pkg::OP_MUL_DTE:  acc_r <= prod_r;
      pidlp_pkg::OP_NUM_ADD:  acc_r <= acc_r + prod_r;
      pidlp_pkg::OP_P_TAKE:   p_r <= rnd;
      pidlp_pkg::OP_T_TAKE:   t_r <= tcl[TERM_W-1:0];
      pidlp_pkg::OP_I_TAKE:   sat_r <= sat_r | isat.hit;
      pidlp_pkg::OP_DDIV_END: d_r <= div_quot;
      pidlp_pkg::OP_SUM: begin
        drive_r   <= fsat.v;
        out_sat_r <= sat_r | fsat.hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == pidlp_pkg::OP_SUM) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_drive      = drive_r;
  assign out_saturated  = out_sat_r;

  a_sum_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pidlp_pkg::OP_SUM) |-> (!out_valid_r || out_ready))
    else $error("result written over a pending item");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pidlp_pkg::OP_FDIV_END || cmd.op == pidlp_pkg::OP_DDIV_END)
      |-> div_done)
    else $error("quotient taken before divider finished");

  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pidlp_pkg::OP_WAIT) |-> (div_busy || div_done || $past(div_start)))
    else $error("waiting on an idle divider");

endmodule

// ===== hdl/pidlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidlp_ctrl
// Sequencer: steps the datapath through filters, P, I, D and the final sum.
// ----------------------------------------------------------------------------
module pidlp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output pidlp_pkg::dp_cmd_t   cmd,
  input  pidlp_pkg::dp_stat_t  stat
);

  pidlp_pkg::ctrl_st_t state_r, state_nxt;
  logic [1:0]          idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      pidlp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pidlp_pkg::ST_F_MUL_TC;
          idx_nxt   = pidlp_pkg::FILT_P;
        end
      end
      pidlp_pkg::ST_F_MUL_TC: state_nxt = pidlp_pkg::ST_F_MUL_DT;
      pidlp_pkg::ST_F_MUL_DT: state_nxt = pidlp_pkg::ST_F_ADD;
      pidlp_pkg::ST_F_ADD:    state_nxt = pidlp_pkg::ST_F_DIV;
      pidlp_pkg::ST_F_DIV:    state_nxt = pidlp_pkg::ST_F_WAIT;
      pidlp_pkg::ST_F_WAIT: begin
        if (stat.div_done) begin
          if (idx_r == pidlp_pkg::FILT_D) begin
            state_nxt = pidlp_pkg::ST_P_MUL;
          end else begin
            state_nxt = pidlp_pkg::ST_F_MUL_TC;
            idx_nxt   = idx_r + 2'd1;
          end
        end
      end
      pidlp_pkg::ST_P_MUL:    state_nxt = pidlp_pkg::ST_P_TAKE;
      pidlp_pkg::ST_P_TAKE:   state_nxt = pidlp_pkg::ST_I_MUL;
      pidlp_pkg::ST_I_MUL:    state_nxt = pidlp_pkg::ST_I_TAKE;
      pidlp_pkg::ST_I_TAKE:   state_nxt = pidlp_pkg::ST_I_MUL_DT;
      pidlp_pkg::ST_I_MUL_DT: state_nxt = pidlp_pkg::ST_I_ADD;
      pidlp_pkg::ST_I_ADD:    state_nxt = pidlp_pkg::ST_D_MUL;
      pidlp_pkg::ST_D_MUL:    state_nxt = pidlp_pkg::ST_D_DIV;
      pidlp_pkg::ST_D_DIV:    state_nxt = pidlp_pkg::ST_D_WAIT;
      pidlp_pkg::ST_D_WAIT: begin
        if (stat.div_done) begin
          state_nxt = pidlp_pkg::ST_SUM;
        end
      end
      pidlp_pkg::ST_SUM: begin
        if (stat.out_free) begin
          state_nxt = pidlp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pidlp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.idx  = idx_r;
    cmd.op   = pidlp_pkg::OP_IDLE;
    in_ready = 1'b0;
    case (state_r)
      pidlp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = pidlp_pkg::OP_LATCH;
        end
      end
      pidlp_pkg::ST_F_MUL_TC: cmd.op = pidlp_pkg::OP_MUL_TCF;
      pidlp_pkg::ST_F_MUL_DT: cmd.op = pidlp_pkg::OP_MUL_DTE;
      pidlp_pkg::ST_F_ADD:    cmd.op = pidlp_pkg::OP_NUM_ADD;
      pidlp_pkg::ST_F_DIV:    cmd.op = pidlp_pkg::OP_FDIV_GO;
      pidlp_pkg::ST_F_WAIT: begin
        cmd.op = stat.div_done ? pidlp_pkg::OP_FDIV_END : pidlp_pkg::OP_WAIT;
      end
      pidlp_pkg::ST_P_MUL:    cmd.op = pidlp_pkg::OP_MUL_P;
      pidlp_pkg::ST_P_TAKE:   cmd.op = pidlp_pkg::OP_P_TAKE;
      pidlp_pkg::ST_I_MUL:    cmd.op = pidlp_pkg::OP_MUL_I;
      pidlp_pkg::ST_I_TAKE:   cmd.op = pidlp_pkg::OP_T_TAKE;
      pidlp_pkg::ST_I_MUL_DT: cmd.op = pidlp_pkg::OP_MUL_TDT;
      pidlp_pkg::ST_I_ADD:    cmd.op = pidlp_pkg::OP_I_TAKE;
      pidlp_pkg::ST_D_MUL:    cmd.op = pidlp_pkg::OP_MUL_D;
      pidlp_pkg::ST_D_DIV:    cmd.op = pidlp_pkg::OP_DDIV_GO;
      pidlp_pkg::ST_D_WAIT: begin
        cmd.op = stat.div_done ? pidlp_pkg::OP_DDIV_END : pidlp_pkg::OP_WAIT;
      end
      pidlp_pkg::ST_SUM: begin
        if (stat.out_free) begin
          cmd.op = pidlp_pkg::OP_SUM;
        end
      end
      default: cmd.op = pidlp_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidlp_pkg::ST_IDLE;
      idx_r   <= pidlp_pkg::FILT_P;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd3)
    else $error("filter slot out of range");

endmodule

// ===== hdl/pid_with_term_lowpass.sv =====
// ----------------------------------------------------------------------------
// pid_with_term_lowpass
// PID controller with a first-order low-pass filter on the error per term.
// The shared divider yields one quotient bit per cycle while it is busy and
//   runs four times per item (three filters and the derivative); a stalled
//   result holds the final sum until it drains.
// The next item is taken while a finished result still waits in the output
//   register.
// Reset: synchronous active-low rst_n clears gains, time constants, filter
//   state, the integral and the output valid.
// ----------------------------------------------------------------------------
module pid_with_term_lowpass #(
  parameter int FRAC_BITS = pidlp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [pidlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  // Input item channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [31:0]               in_error_sample,
  input  logic [15:0]                      in_elapsed_ticks,
  // Result item channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               out_drive,
  output logic                             out_saturated
);

  pidlp_pkg::dp_cmd_t  cmd;
  pidlp_pkg::dp_stat_t stat;

  // Sequencer: accepts an item in idle, then walks the datapath through
  // each filter (two products, add, divide), then P, I and D, then the sum.
  pidlp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  // Datapath: holds the registers, the model state, one shared multiplier,
  // the divider and the output register that parts the two channels.
  pidlp_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_error_sample (in_error_sample),
    .in_elapsed_ticks(in_elapsed_ticks),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive       (out_drive),
    .out_saturated   (out_saturated)
  );

endmodule
